### hdl/pisp_pkg.sv
`default_nettype none
package pisp_pkg;

   localparam int PaletteEntries = 256;
   localparam logic [31:0] PaletteBytes = 32'(PaletteEntries * 4);

   typedef enum logic [4:0] {
      PH_MAGIC, PH_TYPE1, PH_HLEN, PH_HFIELDS, PH_HSKIP, PH_TYPE2,
      PH_PLEN, PH_PFIELDS, PH_PSKIP, PH_PTYPE, PH_PDLEN, PH_PPAD1,
      PH_PWORDS, PH_PPAD2, PH_TYPE3, PH_DLEN, PH_DPAD, PH_PIXELS, PH_DROP
   } phase_type;

   localparam logic [1:0] KIND_PIXEL   = 2'd0;
   localparam logic [1:0] KIND_PALETTE = 2'd1;
   localparam logic [1:0] KIND_STATUS  = 2'd2;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_INVALID     = 2'd1;
   localparam logic [1:0] ST_UNSUPPORTED = 2'd2;
   localparam logic [1:0] ST_ZERODIM     = 2'd3;

   localparam logic [31:0] TYPE_HEADER_A = 32'h03;
   localparam logic [31:0] TYPE_HEADER_B = 32'h3D;
   localparam logic [31:0] TYPE_DATA     = 32'h21;
   localparam logic [31:0] PAL_DATA_LEN  = 32'd1032;
   localparam logic [31:0] MIN_HDR_LEN   = 32'd11;
   localparam logic [33:0] SEEN_MAX      = '1;

   typedef struct packed {
      logic [1:0]  out_kind;
      logic [31:0] out_data;
      logic        row_end;
      logic [1:0]  status;
      logic [2:0]  pixel_format;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic        default_palette;
      logic        last;
   } result_type;

   typedef struct packed {
      logic       valid0;
      logic       valid1;
      result_type data0;
      result_type data1;
   } push_type;

   typedef struct packed {
      logic       hit;
      logic [2:0] pix_fmt;
      logic [2:0] bpp;
   } fmt_type;

   function automatic logic [31:0] magic_word(input logic [1:0] idx);
      logic [31:0] w;
      case (idx)
         2'd0:    w = 32'h12;
         2'd1:    w = 32'h08;
         default: w = 32'h02;
      endcase
      return w;
   endfunction

   function automatic fmt_type fmt_lookup(input logic [7:0] code);
      fmt_type f;
      f = '0;
      f.hit = 1'b1;
      case (code)
         8'd3:    begin f.pix_fmt = 3'd0; f.bpp = 3'd1; end
         8'd4:    begin f.pix_fmt = 3'd1; f.bpp = 3'd2; end
         8'd5:    begin f.pix_fmt = 3'd2; f.bpp = 3'd2; end
         8'd6:    begin f.pix_fmt = 3'd3; f.bpp = 3'd3; end
         8'd7:    begin f.pix_fmt = 3'd4; f.bpp = 3'd4; end
         8'd8:    begin f.pix_fmt = 3'd5; f.bpp = 3'd4; end
         8'd18:   begin f.pix_fmt = 3'd6; f.bpp = 3'd2; end
         default: f.hit = 1'b0;
      endcase
      return f;
   endfunction

endpackage
`default_nettype wire

### hdl/pisp_parser.sv
`default_nettype none
module pisp_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [7:0]        byte_value,
   input  wire logic              packet_end,
   output pisp_pkg::push_type     push
);
   import pisp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [31:0] fc_ff, fc_in, sw_ff, sw_in, hlen_ff, hlen_in, chunk_ff, chunk_in;
   logic [7:0]  fmt_ff, fmt_in;
   logic [15:0] width_ff, width_in, height_ff, height_in;
   logic [2:0]  bpp_ff, bpp_in, pixfmt_ff, pixfmt_in;
   logic [33:0] seen_ff, seen_in;
   logic [17:0] row_ff, row_in, row_len_ff;
   logic [1:0]  err_ff, err_in;
   logic        defpal_ff, defpal_in;
   logic [31:0] wh_ff;
   logic [33:0] size_ff;

   logic [31:0] fc1, sw_take;
   logic [17:0] row1;
   fmt_type     fmt_hit;
   logic        emit_v, emit_rend, ok_end;
   logic [1:0]  emit_kind, end_st;
   logic [31:0] emit_data;
   result_type  base, res_a, res_s;

   assign fc1     = fc_ff + 32'd1;
   assign sw_take = {sw_ff[23:0], byte_value};
   assign row1    = row_ff + 18'd1;
   assign fmt_hit = fmt_lookup(fmt_ff);

   always_comb begin
      phase_in = phase_ff; fc_in = fc_ff; sw_in = sw_ff; hlen_in = hlen_ff;
      chunk_in = chunk_ff; fmt_in = fmt_ff; width_in = width_ff;
      height_in = height_ff; bpp_in = bpp_ff; pixfmt_in = pixfmt_ff;
      seen_in = seen_ff; row_in = row_ff; err_in = err_ff; defpal_in = defpal_ff;
      emit_v = 1'b0; emit_kind = KIND_PIXEL; emit_data = '0; emit_rend = 1'b0;
      case (phase_ff)
         PH_MAGIC: begin
            fc_in = fc1; sw_in = sw_take;
            if (fc1[1:0] == 2'd0) begin
               if (sw_take != magic_word(fc1[3:2] - 2'd1)) begin
                  err_in = ST_INVALID; phase_in = PH_DROP;
               end else if (fc1 == 32'd16) begin
                  phase_in = PH_TYPE1; fc_in = '0; sw_in = '0;
               end else begin
                  sw_in = '0;
               end
            end
         end
         PH_TYPE1: begin
            fc_in = fc1; sw_in = sw_take;
            if (fc1 == 32'd4) begin
               if (sw_take != TYPE_HEADER_A && sw_take != TYPE_HEADER_B) begin
                  err_in = ST_INVALID; phase_in = PH_DROP;
               end else begin
                  phase_in = PH_HLEN; fc_in = '0; sw_in = '0;
               end
            end
         end
         PH_HLEN, PH_PLEN: begin
            fc_in = fc1; sw_in = sw_take;
            if (fc1 == 32'd4) begin
               hlen_in = sw_take; fc_in = '0; sw_in = '0;
               phase_in = (phase_ff == PH_HLEN) ? PH_HFIELDS : PH_PFIELDS;
            end
         end
         PH_HFIELDS: begin
            fc_in = fc1; sw_in = sw_take;
            if (fc1 == 32'd1) begin
               fmt_in = byte_value;
            end else if (fc1 == 32'd5) begin
               width_in = sw_take[15:0];
            end else if (fc1 == 32'd7) begin
               height_in = sw_take[15:0];
               if (hlen_ff < MIN_HDR_LEN) begin
                  err_in = ST_INVALID; phase_in = PH_DROP;
               end else if (!fmt_hit.hit) begin
                  err_in = ST_UNSUPPORTED; phase_in = PH_DROP;
               end else begin
                  pixfmt_in = fmt_hit.pix_fmt; bpp_in = fmt_hit.bpp;
                  if (width_ff == 16'd0 || sw_take[15:0] == 16'd0) begin
                     err_in = ST_ZERODIM; phase_in = PH_DROP;
                  end else begin
                     phase_in = PH_HSKIP; fc_in = '0; sw_in = '0;
                  end
               end
            end
         end
         PH_PFIELDS: begin
            fc_in = fc1;
            if (fc1 == 32'd7) begin
               if (hlen_ff < MIN_HDR_LEN) begin
                  err_in = ST_INVALID; phase_in = PH_DROP;
               end else begin
                  phase_in = PH_PSKIP; fc_in = '0; sw_in = '0;
               end
            end
         end
         PH_HSKIP, PH_PSKIP: begin
            fc_in = fc1;
            if (fc1 == hlen_ff - 32'd7) begin
               phase_in = (phase_ff == PH_HSKIP) ? PH_TYPE2 : PH_PTYPE;
               fc_in = '0; sw_in = '0;
            end
         end
         PH_TYPE2: begin
            fc_in = fc1; sw_in = sw_take;
            if (fc1 == 32'd4) begin
               if (pixfmt_ff == 3'd0 &&
                   (sw_take == TYPE_HEADER_A || sw_take == TYPE_HEADER_B)) begin
                  phase_in = PH_PLEN; fc_in = '0; sw_in = '0;
               end else begin
                  if (pixfmt_ff == 3'd0) defpal_in = 1'b1;
                  if (sw_take != TYPE_DATA) begin
                     err_in = ST_INVALID; phase_in = PH_DROP;
                  end else begin
                     phase_in = PH_DLEN; fc_in = '0; sw_in = '0;
                  end
               end
            end
         end
         PH_PTYPE, PH_TYPE3: begin
            fc_in = fc1; sw_in = sw_take;
            if (fc1 == 32'd4) begin
               if (sw_take != TYPE_DATA) begin
                  err_in = ST_INVALID; phase_in = PH_DROP;
               end else begin
                  phase_in = (phase_ff == PH_PTYPE) ? PH_PDLEN : PH_DLEN;
                  fc_in = '0; sw_in = '0;
               end
            end
         end
         PH_PDLEN: begin
            fc_in = fc1; sw_in = sw_take;
            if (fc1 == 32'd4) begin
               if (sw_take != PAL_DATA_LEN) begin
                  err_in = ST_INVALID; phase_in = PH_DROP;
               end else begin
                  phase_in = PH_PPAD1; fc_in = '0; sw_in = '0;
               end
            end
         end
         PH_PPAD1, PH_PPAD2, PH_DPAD: begin
            fc_in = fc1;
            if (fc1 == 32'd8) begin
               fc_in = '0; sw_in = '0;
               if (phase_ff == PH_PPAD1) begin
                  phase_in = PH_PWORDS;
               end else if (phase_ff == PH_PPAD2) begin
                  phase_in = PH_TYPE3;
               end else begin
                  phase_in = PH_PIXELS; seen_in = '0; row_in = '0;
               end
            end
         end
         PH_PWORDS: begin
            fc_in = fc1; sw_in = sw_take;
            if (fc1[1:0] == 2'd0) begin
               emit_v = 1'b1; emit_kind = KIND_PALETTE;
               emit_data = sw_take | 32'hFF00_0000;
               sw_in = '0;
            end
            if (fc1 == PaletteBytes) begin
               phase_in = PH_PPAD2; fc_in = '0; sw_in = '0;
            end
         end
         PH_DLEN: begin
            fc_in = fc1; sw_in = sw_take;
            if (fc1 == 32'd4) begin
               chunk_in = sw_take; phase_in = PH_DPAD; fc_in = '0; sw_in = '0;
            end
         end
         PH_PIXELS: begin
            if (seen_ff < size_ff) begin
               emit_v = 1'b1; emit_kind = KIND_PIXEL;
               emit_data = {24'd0, byte_value};
               if (row1 >= row_len_ff) begin
                  emit_rend = 1'b1; row_in = '0;
               end else begin
                  row_in = row1;
               end
            end
            if (seen_ff != SEEN_MAX) seen_in = seen_ff + 34'd1;
         end
         default: begin
         end
      endcase

      ok_end = (phase_in == PH_PIXELS) && (seen_in == {2'b00, chunk_in}) &&
               (seen_in >= size_ff);
      end_st = (err_in == ST_OK && !ok_end) ? ST_INVALID : err_in;

      base = '0;
      base.pixel_format    = pixfmt_in;
      base.image_width     = width_in;
      base.image_height    = height_in;
      base.default_palette = defpal_in;
      res_a = base;
      res_a.out_kind = emit_kind;
      res_a.out_data = emit_data;
      res_a.row_end  = emit_rend;
      res_a.last     = !packet_end;
      res_s = base;
      res_s.out_kind = KIND_STATUS;
      res_s.status   = end_st;
      res_s.last     = 1'b1;

      push = '0;
      if (accept) begin
         if (emit_v) begin
            push.valid0 = 1'b1; push.data0 = res_a;
            push.valid1 = packet_end; push.data1 = res_s;
         end else begin
            push.valid0 = packet_end; push.data0 = res_s;
         end
      end

      if (packet_end) begin
         phase_in = PH_MAGIC; fc_in = '0; sw_in = '0; hlen_in = '0;
         chunk_in = '0; fmt_in = '0; width_in = '0; height_in = '0;
         bpp_in = '0; pixfmt_in = '0; seen_in = '0; row_in = '0;
         err_in = ST_OK; defpal_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAGIC; fc_ff <= '0; sw_ff <= '0; hlen_ff <= '0;
         chunk_ff <= '0; fmt_ff <= '0; width_ff <= '0; height_ff <= '0;
         bpp_ff <= '0; pixfmt_ff <= '0; seen_ff <= '0; row_ff <= '0;
         err_ff <= ST_OK; defpal_ff <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in; fc_ff <= fc_in; sw_ff <= sw_in; hlen_ff <= hlen_in;
         chunk_ff <= chunk_in; fmt_ff <= fmt_in; width_ff <= width_in;
         height_ff <= height_in; bpp_ff <= bpp_in; pixfmt_ff <= pixfmt_in;
         seen_ff <= seen_in; row_ff <= row_in; err_ff <= err_in;
         defpal_ff <= defpal_in;
      end
   end

   // The image size settles long before the first pixel byte arrives.
   always_ff @(posedge clock) begin
      wh_ff      <= 32'(width_ff) * 32'(height_ff);
      size_ff    <= 34'(wh_ff) * 34'(bpp_ff);
      row_len_ff <= 18'(width_ff) * 18'(bpp_ff);
   end

endmodule
`default_nettype wire

### hdl/pisp_out_fifo.sv
`default_nettype none
module pisp_out_fifo (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire pisp_pkg::push_type    push,
   input  wire logic                  pop,
   output pisp_pkg::result_type       head,
   output logic                       not_empty,
   output logic                       room
);
   import pisp_pkg::*;

   result_type  mem_ff [4];
   logic [1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0]  count_ff, count_in;
   logic [1:0]  wp_next;

   assign wp_next   = wp_ff + 2'd1;
   assign head      = mem_ff[rp_ff];
   assign not_empty = (count_ff != 3'd0);
   assign room      = (count_ff <= 3'd2);

   always_comb begin
      wp_in    = wp_ff + 2'(push.valid0) + 2'(push.valid1);
      rp_in    = rp_ff + 2'(pop);
      count_in = count_ff + 3'(push.valid0) + 3'(push.valid1) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.valid0) mem_ff[wp_ff] <= push.data0;
      if (push.valid1) mem_ff[wp_next] <= push.data1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; count_ff <= '0;
      end else begin
         wp_ff <= wp_in; rp_ff <= rp_in; count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

### hdl/pix_image_stream_parser.sv
// Image packet parser. Packet bytes enter on the req_ channel, one per
// transfer, with req_packet_end high on the final byte. Results leave on the
// rsp_ channel: pixel bytes (with rsp_row_end on the last byte of a scanline),
// palette words with alpha forced to 0xFF, and one status result per packet.
// rsp_last marks the final result caused by one input byte.
// A byte is parsed in the cycle it is accepted and its results are registered
// in a four-entry output queue, whose head drives the rsp_ channel. One byte
// is accepted per cycle while the queue has room for two results; a byte that
// causes two results (a pixel or palette word plus the status) fills two
// queue entries, which drain one at a time.
// When the receiver stalls, the queue fills and req_ready drops once fewer
// than two free entries remain; nothing is lost.
// Reset returns the parser to the magic search and empties the queue. After
// every status result the parser state returns to its reset values as well.
// The image size product is computed in two registered multiply stages that
// finish while the chunk headers are still arriving.
`default_nettype none
module pix_image_stream_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic        req_packet_end,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [1:0]       rsp_out_kind,
   output logic [31:0]      rsp_out_data,
   output logic             rsp_row_end,
   output logic [1:0]       rsp_status,
   output logic [2:0]       rsp_pixel_format,
   output logic [15:0]      rsp_image_width,
   output logic [15:0]      rsp_image_height,
   output logic             rsp_default_palette,
   output logic             rsp_last
);
   import pisp_pkg::*;

   push_type   push;
   result_type head;
   logic       room;
   logic       accept;

   assign req_ready = room;
   assign accept    = req_valid && room;

   pisp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .byte_value (req_byte_value),
      .packet_end (req_packet_end),
      .push       (push)
   );

   pisp_out_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_valid && rsp_ready),
      .head      (head),
      .not_empty (rsp_valid),
      .room      (room)
   );

   assign rsp_out_kind        = head.out_kind;
   assign rsp_out_data        = head.out_data;
   assign rsp_row_end         = head.row_end;
   assign rsp_status          = head.status;
   assign rsp_pixel_format    = head.pixel_format;
   assign rsp_image_width     = head.image_width;
   assign rsp_image_height    = head.image_height;
   assign rsp_default_palette = head.default_palette;
   assign rsp_last            = head.last;

endmodule
`default_nettype wire

### hdl/pisp_checker.sv
`default_nettype none
module pisp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_out_kind,
   input wire logic [31:0] rsp_out_data,
   input wire logic        rsp_row_end,
   input wire logic        rsp_last
);
   import pisp_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_data))
      else $error("result changed while stalled");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == KIND_STATUS |-> rsp_last && rsp_out_data == 32'd0)
      else $error("status result is not last or carries data");

   a_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind != KIND_PIXEL |-> !rsp_row_end)
      else $error("row end outside pixel result");

   a_palette_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == KIND_PALETTE |-> rsp_out_data[31:24] == 8'hFF)
      else $error("palette word without full alpha");

endmodule

bind pix_image_stream_parser pisp_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_kind (rsp_out_kind),
   .rsp_out_data (rsp_out_data),
   .rsp_row_end  (rsp_row_end),
   .rsp_last     (rsp_last)
);
`default_nettype wire
